[hw/rtl/tdpt_pkg.sv]
package tdpt_pkg;

    localparam int VALUE_BITS = 24;
    localparam int SQ_BITS    = VALUE_BITS + 2;
    localparam int CNT_BITS   = (VALUE_BITS > 2) ? $clog2(VALUE_BITS) : 1;

    localparam logic [CNT_BITS-1:0] DIV_LAST_COUNT = CNT_BITS'(VALUE_BITS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_TEST,
        S_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic div_start;
        logic div_step;
        logic next_div;
    } cmd_t;

    typedef struct packed {
        logic lt2;
        logic sq_gt_n;
        logic div_last;
        logic rem_zero;
    } status_t;

endpackage

[hw/rtl/tdpt_datapath.sv]
module tdpt_datapath (
    input  logic                             aclk,
    input  logic [tdpt_pkg::VALUE_BITS-1:0]  candidate,
    input  tdpt_pkg::cmd_t                   cmd,
    output tdpt_pkg::status_t                status
);
    import tdpt_pkg::*;

    logic [VALUE_BITS-1:0] n_reg, n_next;
    logic [VALUE_BITS-1:0] d_reg, d_next;
    logic [SQ_BITS-1:0]    sq_reg, sq_next;
    logic [VALUE_BITS-1:0] rem_reg, rem_next;
    logic [VALUE_BITS-1:0] q_reg, q_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic [VALUE_BITS:0]   rem_sh;
    logic [VALUE_BITS:0]   rem_sub;

    // one restoring division step per cycle
    always_comb begin
        rem_sh  = {rem_reg, q_reg[VALUE_BITS-1]};
        rem_sub = rem_sh - {1'b0, d_reg};
    end

    always_comb begin
        n_next   = n_reg;
        d_next   = d_reg;
        sq_next  = sq_reg;
        rem_next = rem_reg;
        q_next   = q_reg;
        cnt_next = cnt_reg;
        if (cmd.load) begin
            n_next  = candidate;
            d_next  = VALUE_BITS'(2);
            sq_next = SQ_BITS'(4);
        end
        if (cmd.next_div) begin
            d_next  = d_reg + VALUE_BITS'(1);
            sq_next = sq_reg + SQ_BITS'({d_reg, 1'b1});
        end
        if (cmd.div_start) begin
            rem_next = '0;
            q_next   = n_reg;
            cnt_next = DIV_LAST_COUNT;
        end
        if (cmd.div_step) begin
            q_next   = {q_reg[VALUE_BITS-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_BITS'(1);
            if (!rem_sub[VALUE_BITS]) begin
                rem_next = rem_sub[VALUE_BITS-1:0];
            end else begin
                rem_next = rem_sh[VALUE_BITS-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        n_reg   <= n_next;
        d_reg   <= d_next;
        sq_reg  <= sq_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        cnt_reg <= cnt_next;
    end

    always_comb begin
        status.lt2      = (n_reg[VALUE_BITS-1:1] == '0);
        status.sq_gt_n  = (sq_reg > SQ_BITS'(n_reg));
        status.div_last = (cnt_reg == '0);
        status.rem_zero = (rem_reg == '0);
    end

endmodule

[hw/rtl/tdpt_ctrl.sv]
module tdpt_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_is_prime,
    output tdpt_pkg::cmd_t    cmd,
    input  tdpt_pkg::status_t status
);
    import tdpt_pkg::*;

    state_t state_reg, state_next;
    logic   res_reg, res_next;
    logic   out_valid_reg, out_valid_next;
    logic   is_prime_reg, is_prime_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
        res_reg      <= res_next;
        is_prime_reg <= is_prime_next;
    end

    always_comb begin
        state_next     = state_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        is_prime_next  = is_prime_reg;
        cmd            = '0;
        s_ready        = 1'b0;
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                priority if (status.lt2) begin
                    res_next   = 1'b0;
                    state_next = S_DONE;
                end else if (status.sq_gt_n) begin
                    res_next   = 1'b1;
                    state_next = S_DONE;
                end else begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = S_TEST;
                end
            end
            S_TEST: begin
                if (status.rem_zero) begin
                    res_next   = 1'b0;
                    state_next = S_DONE;
                end else begin
                    cmd.next_div = 1'b1;
                    state_next   = S_CHECK;
                end
            end
            S_DONE: begin
                if (slot_free) begin
                    out_valid_next = 1'b1;
                    is_prime_next  = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_valid    = out_valid_reg;
    assign m_is_prime = is_prime_reg;

    a_accept_to_check: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == S_CHECK))
        else $error("accepted transaction did not start a check");

    a_small_not_prime: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CHECK && status.lt2) |=> (state_reg == S_DONE && !res_reg))
        else $error("zero or one not flagged as not prime");

    a_div_to_test: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV && status.div_last) |=> (state_reg == S_TEST))
        else $error("division did not end after last step");

    a_result_posted: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && slot_free)
        |=> (m_valid && m_is_prime == $past(res_reg) && state_reg == S_IDLE))
        else $error("result not posted to output register");

endmodule

[hw/rtl/trial_division_prime_test.sv]
// Trial-division primality test. Each input transaction carries one unsigned
// candidate and yields one result transaction with is_prime set when the
// candidate is prime; zero and one report not prime. Divisors 2, 3, 4 and on
// are tried until one divides the candidate or its square exceeds the
// candidate. Each trial runs through a shared restoring divider that takes
// one bit per cycle, and the remainder is then tested for zero. One item
// is in work at a time; a finished result waits in an output register
// while the next candidate is accepted.
module trial_division_prime_test (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [tdpt_pkg::VALUE_BITS-1:0]  s_candidate,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_is_prime
);
    import tdpt_pkg::*;

    cmd_t    cmd;
    status_t status;

    tdpt_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_is_prime (m_is_prime),
        .cmd        (cmd),
        .status     (status)
    );

    tdpt_datapath u_datapath (
        .aclk      (aclk),
        .candidate (s_candidate),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
